FILE: hw/rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Shared widths, frame positions, state and job codes, and the command and
// status structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CHAN_W     = 11;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int POS_W      = 5;
    localparam int ACC_W      = 19;
    localparam int PCT_W      = 16;
    localparam int THR_W      = 15;
    localparam int DIVIDEND_W = 27;
    localparam int SPAN_W     = 16;

    localparam logic [POS_W-1:0] FRAME_LEN     = 5'd25;
    localparam logic [POS_W-1:0] FLAGS_POS     = 5'd23;
    localparam logic [POS_W-1:0] LAST_DATA_POS = 5'd22;
    localparam logic [POS_W-1:0] FIRST_POS     = 5'd1;
    localparam logic [POS_W-1:0] NUM_CHANS     = 5'd16;
    localparam logic [POS_W-1:0] BITS_PER_BYTE = 5'd8;
    localparam logic [POS_W-1:0] BITS_PER_CHAN = 5'd11;

    localparam logic [SPAN_W-1:0] Q_FULL_SPAN = 16'd51200;
    localparam logic [SPAN_W-1:0] Q_HALF_SPAN = 16'd25600;

    localparam logic [CHAN_W-1:0] RST_CH_LOW  = 11'd172;
    localparam logic [CHAN_W-1:0] RST_CH_HIGH = 11'd1811;
    localparam logic [CHAN_W-1:0] RST_ARM_THR = 11'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CH1_LOW,
        CFG_CH1_HIGH,
        CFG_CH3_LOW,
        CFG_CH3_HIGH,
        CFG_ARM_THR
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LOAD,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        JOB_ROLL,
        JOB_THR,
        JOB_YAW
    } t_job;

    typedef struct packed {
        logic latch;
        logic apply;
        logic chan_write;
        logic load;
        t_job job;
        logic div_start;
        logic capture;
        logic status_write;
    } t_cmd;

    typedef struct packed {
        logic is_flags;
        logic emits_chan;
        logic out_busy;
        logic div_done;
    } t_status;

endpackage

FILE: hw/rtl/sfd_div.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sfd_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [sfd_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [sfd_pkg::CHAN_W-1:0]      i_divisor,
    output logic                            o_done,
    output logic [sfd_pkg::DIVIDEND_W-1:0]  o_quot
);
    import sfd_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [CHAN_W-1:0]      r_rem;
    logic [DIVIDEND_W-1:0]  r_work;
    logic [CHAN_W-1:0]      n_rem;
    logic [DIVIDEND_W-1:0]  n_work;
    logic [CHAN_W:0]        trial;
    logic                   fits;

    always_comb begin
        trial  = {r_rem, r_work[DIVIDEND_W-1]};
        fits   = trial >= {1'b0, i_divisor};
        n_rem  = fits ? CHAN_W'(trial - {1'b0, i_divisor}) : trial[CHAN_W-1:0];
        n_work = {r_work[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_work <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_work <= n_work;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

FILE: hw/rtl/sfd_datapath.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder datapath
// Configuration registers, bit packer, percentage scaling and output register.
// ----------------------------------------------------------------------------
module sfd_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [sfd_pkg::CHAN_W-1:0]      i_cfg_data,
    input  logic [sfd_pkg::BYTE_W-1:0]      i_rx_byte,
    input  logic                            i_frame_start,
    input  logic                            i_out_stall,
    input  sfd_pkg::t_cmd                   i_cmd,
    output sfd_pkg::t_status                o_status,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic [sfd_pkg::IDX_W-1:0]       o_chan_index,
    output logic [sfd_pkg::CHAN_W-1:0]      o_chan_value,
    output logic                            o_digital_a,
    output logic                            o_digital_b,
    output logic                            o_lost_frame,
    output logic                            o_failsafe_on,
    output logic signed [sfd_pkg::PCT_W-1:0] o_roll_pct,
    output logic [sfd_pkg::THR_W-1:0]       o_throttle_pct,
    output logic signed [sfd_pkg::PCT_W-1:0] o_yaw_pct,
    output logic                            o_armed
);
    import sfd_pkg::*;

    localparam int SQ_W = DIVIDEND_W + 2;
    localparam logic signed [SQ_W-1:0] SYM_MAX  = 29'sd32767;
    localparam logic signed [SQ_W-1:0] SYM_MIN  = -29'sd32768;
    localparam logic signed [SQ_W-1:0] UNIT_MAX = 29'sd25600;
    localparam logic signed [SQ_W-1:0] SYM_OFF  = 29'sd25600;

    // Configuration
    logic [CHAN_W-1:0] r_ch1_low, r_ch1_high, r_ch3_low, r_ch3_high, r_arm_thr;

    // Captured input item
    logic [BYTE_W-1:0] r_byte;
    logic              r_start;

    // Packer state
    logic [POS_W-1:0]  r_byte_pos;
    logic [ACC_W-1:0]  r_acc;
    logic [POS_W-1:0]  r_bc;
    logic [POS_W-1:0]  r_cc;
    logic [CHAN_W-1:0] r_saved1, r_saved3, r_saved4;

    // Scaling operands and results
    logic [DIVIDEND_W-1:0] r_mag;
    logic [CHAN_W-1:0]     r_den;
    logic                  r_neg;
    logic                  r_empty;
    logic signed [PCT_W-1:0] r_roll, r_yaw;
    logic [THR_W-1:0]      r_thr;

    // Output register
    logic                  r_out_valid;
    logic                  r_kind;
    logic [IDX_W-1:0]      r_idx;
    logic [CHAN_W-1:0]     r_val;
    logic [3:0]            r_flags;
    logic signed [PCT_W-1:0] r_o_roll, r_o_yaw;
    logic [THR_W-1:0]      r_o_thr;
    logic                  r_armed;

    logic                  in_data;
    logic [23:0]           acc_new;
    logic [POS_W-1:0]      bc_new;
    logic                  emit;

    logic [CHAN_W-1:0]     sel_v, sel_lo, sel_hi;
    logic [CHAN_W:0]       diff, range;
    logic [CHAN_W-1:0]     abs_diff;
    logic [SPAN_W-1:0]     span;
    logic [DIVIDEND_W-1:0] mag_prod;

    logic [DIVIDEND_W-1:0] dividend;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] quot;
    logic signed [SQ_W-1:0] sq;
    logic signed [SQ_W-1:0] shifted;
    logic signed [PCT_W-1:0] sym_sat;
    logic [THR_W-1:0]      unit_sat;

    // Packer decode for the held byte.
    always_comb begin
        in_data = (r_byte_pos >= FIRST_POS) && (r_byte_pos <= LAST_DATA_POS);
        acc_new = {5'b0, r_acc} | ({16'b0, r_byte} << r_bc[3:0]);
        bc_new  = r_bc + BITS_PER_BYTE;
        emit    = !r_start && in_data && (bc_new >= BITS_PER_CHAN) && (r_cc < NUM_CHANS);
    end

    assign o_status.is_flags   = !r_start && (r_byte_pos == FLAGS_POS);
    assign o_status.emits_chan = emit;
    assign o_status.out_busy   = r_out_valid && i_out_stall;
    assign o_status.div_done   = div_done;

    // Operand setup for one scaling job.
    always_comb begin
        sel_v    = (i_cmd.job == JOB_YAW) ? r_saved3   : r_saved1;
        sel_lo   = (i_cmd.job == JOB_YAW) ? r_ch3_low  : r_ch1_low;
        sel_hi   = (i_cmd.job == JOB_YAW) ? r_ch3_high : r_ch1_high;
        diff     = {1'b0, sel_v} - {1'b0, sel_lo};
        range    = {1'b0, sel_hi} - {1'b0, sel_lo};
        abs_diff = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
        span     = (i_cmd.job == JOB_THR) ? Q_HALF_SPAN : Q_FULL_SPAN;
        mag_prod = {{(DIVIDEND_W-CHAN_W){1'b0}}, abs_diff}
                 * {{(DIVIDEND_W-SPAN_W){1'b0}}, span};
    end

    // Adding half the divisor turns the floor division into round-to-nearest.
    assign dividend = r_mag + {{(DIVIDEND_W-CHAN_W+1){1'b0}}, r_den[CHAN_W-1:1]};

    sfd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (r_den),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Sign, offset and saturation of the quotient.
    always_comb begin
        sq      = r_neg ? -$signed({2'b0, quot}) : $signed({2'b0, quot});
        shifted = (i_cmd.job == JOB_THR) ? sq : sq - SYM_OFF;
        if (shifted > SYM_MAX) begin
            sym_sat = PCT_W'(SYM_MAX);
        end else if (shifted < SYM_MIN) begin
            sym_sat = PCT_W'(SYM_MIN);
        end else begin
            sym_sat = shifted[PCT_W-1:0];
        end
        if (shifted < 0) begin
            unit_sat = '0;
        end else if (shifted > UNIT_MAX) begin
            unit_sat = THR_W'(UNIT_MAX);
        end else begin
            unit_sat = shifted[THR_W-1:0];
        end
        if (r_empty) begin
            sym_sat  = '0;
            unit_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch1_low  <= RST_CH_LOW;
            r_ch1_high <= RST_CH_HIGH;
            r_ch3_low  <= RST_CH_LOW;
            r_ch3_high <= RST_CH_HIGH;
            r_arm_thr  <= RST_ARM_THR;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CH1_LOW:  r_ch1_low  <= i_cfg_data;
                CFG_CH1_HIGH: r_ch1_high <= i_cfg_data;
                CFG_CH3_LOW:  r_ch3_low  <= i_cfg_data;
                CFG_CH3_HIGH: r_ch3_high <= i_cfg_data;
                CFG_ARM_THR:  r_arm_thr  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos <= FRAME_LEN;
            r_acc      <= '0;
            r_bc       <= '0;
            r_cc       <= '0;
            r_saved1   <= '0;
            r_saved3   <= '0;
            r_saved4   <= '0;
        end else if (i_cmd.apply) begin
            if (r_start) begin
                r_byte_pos <= FIRST_POS;
                r_acc      <= '0;
                r_bc       <= '0;
                r_cc       <= '0;
            end else if (r_byte_pos < FRAME_LEN) begin
                r_byte_pos <= r_byte_pos + 1'b1;
                if (in_data) begin
                    if (emit) begin
                        r_acc <= ACC_W'(acc_new >> CHAN_W);
                        r_bc  <= bc_new - BITS_PER_CHAN;
                        r_cc  <= r_cc + 1'b1;
                        if (r_cc == 5'd1) r_saved1 <= acc_new[CHAN_W-1:0];
                        if (r_cc == 5'd3) r_saved3 <= acc_new[CHAN_W-1:0];
                        if (r_cc == 5'd4) r_saved4 <= acc_new[CHAN_W-1:0];
                    end else begin
                        r_acc <= acc_new[ACC_W-1:0];
                        r_bc  <= bc_new;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_byte  <= i_rx_byte;
            r_start <= i_frame_start;
        end
        if (i_cmd.load) begin
            r_mag   <= mag_prod;
            r_den   <= range[CHAN_W-1:0];
            r_neg   <= diff[CHAN_W];
            r_empty <= range[CHAN_W] || (range == '0);
        end
        if (i_cmd.capture) begin
            case (i_cmd.job)
                JOB_ROLL: r_roll <= sym_sat;
                JOB_THR:  r_thr  <= unit_sat;
                JOB_YAW:  r_yaw  <= sym_sat;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.chan_write || i_cmd.status_write) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.chan_write) begin
            r_kind   <= 1'b0;
            r_idx    <= r_cc[IDX_W-1:0];
            r_val    <= acc_new[CHAN_W-1:0];
            r_flags  <= '0;
            r_o_roll <= '0;
            r_o_thr  <= '0;
            r_o_yaw  <= '0;
            r_armed  <= 1'b0;
        end else if (i_cmd.status_write) begin
            r_kind   <= 1'b1;
            r_idx    <= '0;
            r_val    <= '0;
            r_flags  <= r_byte[3:0];
            r_o_roll <= r_roll;
            r_o_thr  <= r_thr;
            r_o_yaw  <= r_yaw;
            r_armed  <= r_saved4 > r_arm_thr;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_chan_index   = r_idx;
    assign o_chan_value   = r_val;
    assign o_digital_a    = r_flags[0];
    assign o_digital_b    = r_flags[1];
    assign o_lost_frame   = r_flags[2];
    assign o_failsafe_on  = r_flags[3];
    assign o_roll_pct     = r_o_roll;
    assign o_throttle_pct = r_o_thr;
    assign o_yaw_pct      = r_o_yaw;
    assign o_armed        = r_armed;

endmodule

FILE: hw/rtl/sfd_ctrl.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder controller
// Sequences byte capture, packing, the three scaling divides and result writes.
// ----------------------------------------------------------------------------
module sfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  sfd_pkg::t_status  i_status,
    output logic              o_in_stall,
    output sfd_pkg::t_cmd     o_cmd
);
    import sfd_pkg::*;

    t_state r_state, n_state;
    t_job   r_job, n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_job   <= JOB_ROLL;
        end else begin
            r_state <= n_state;
            r_job   <= n_job;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        o_cmd      = '0;
        o_cmd.job  = r_job;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_status.is_flags) begin
                    o_cmd.apply = 1'b1;
                    n_job       = JOB_ROLL;
                    n_state     = ST_LOAD;
                end else if (i_status.emits_chan) begin
                    // Packing and the channel result commit together.
                    if (!i_status.out_busy) begin
                        o_cmd.apply      = 1'b1;
                        o_cmd.chan_write = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else begin
                    o_cmd.apply = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_DIV_START;
            end
            ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                if (i_status.div_done) begin
                    o_cmd.capture = 1'b1;
                    case (r_job)
                        JOB_ROLL: begin
                            n_job   = JOB_THR;
                            n_state = ST_LOAD;
                        end
                        JOB_THR: begin
                            n_job   = JOB_YAW;
                            n_state = ST_LOAD;
                        end
                        default: begin
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (!i_status.out_busy) begin
                    o_cmd.status_write = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// SBUS frame decoder
// Unpacks 16 proportional channels from SBUS frame bytes and reports a frame
// status word with scaled roll, throttle and yaw percentages.
// ----------------------------------------------------------------------------
// Bytes arrive one per input transfer; a transfer with frame_start set is byte
// 0 of a new frame and restarts the bit packer while keeping the saved channel
// values. Each channel byte is captured and then decoded, and a byte that
// completes a channel issues one channel result. The flags byte runs three
// 27-step restoring divides on a single shared divider, one for roll, one
// for throttle and one for yaw. Its status result is written once the yaw
// divide is done and the output register is free, and the next byte is
// taken only after that; the divider sets the pace of the flags byte.
// A result waits in the output register while the next byte is taken; a
// decode that emits a channel holds until it is free. Configuration writes
// are always ready and must happen while the block is idle.
// ----------------------------------------------------------------------------
module sbus_frame_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // Configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sfd_pkg::CHAN_W-1:0]       i_cfg_data,

    // Byte input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sfd_pkg::BYTE_W-1:0]       i_rx_byte,
    input  logic                             i_frame_start,

    // Result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_kind,
    output logic [sfd_pkg::IDX_W-1:0]        o_chan_index,
    output logic [sfd_pkg::CHAN_W-1:0]       o_chan_value,
    output logic                             o_digital_a,
    output logic                             o_digital_b,
    output logic                             o_lost_frame,
    output logic                             o_failsafe_on,
    output logic signed [sfd_pkg::PCT_W-1:0] o_roll_pct,
    output logic [sfd_pkg::THR_W-1:0]        o_throttle_pct,
    output logic signed [sfd_pkg::PCT_W-1:0] o_yaw_pct,
    output logic                             o_armed
);
    import sfd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The register file never pushes back, so every write transfer lands at once.
    assign o_cfg_ready = 1'b1;

    // The controller decides when each byte is captured, packed and scaled.
    sfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    // The datapath holds the configuration, packer state, divider and the
    // output register that decouples the two channels.
    sfd_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rx_byte      (i_rx_byte),
        .i_frame_start  (i_frame_start),
        .i_out_stall    (i_out_stall),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_kind         (o_kind),
        .o_chan_index   (o_chan_index),
        .o_chan_value   (o_chan_value),
        .o_digital_a    (o_digital_a),
        .o_digital_b    (o_digital_b),
        .o_lost_frame   (o_lost_frame),
        .o_failsafe_on  (o_failsafe_on),
        .o_roll_pct     (o_roll_pct),
        .o_throttle_pct (o_throttle_pct),
        .o_yaw_pct      (o_yaw_pct),
        .o_armed        (o_armed)
    );

endmodule
